[src/idpo_pkg.sv]
// ----------------------------------------------------------------------------
// idpo_pkg: shared types and constants
// Codes, timeout constants and the structs passed between the settings, core
// and top-level modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idpo_pkg;

  localparam int TICK_W    = 24;
  localparam int ELAPSED_W = TICK_W + 1;
  localparam int TIMEOUT_W = 19;
  localparam int LIGHT_W   = 3;

  // One day of 128 Hz ticks.
  localparam logic [ELAPSED_W-1:0] TICKS_PER_DAY = 25'd11059200;

  localparam int TICKS_PER_MINUTE      = 60 * 128;
  localparam int TICKS_PER_HALF_MINUTE = 30 * 128;

  localparam logic [7:0] APO_CODE_SHORT = 8'd10;
  localparam logic [7:0] APO_CODE_LONG  = 8'd60;
  localparam logic [7:0] DIM_CODE_ONE   = 8'd1;
  localparam logic [7:0] DIM_CODE_TWO   = 8'd2;
  localparam logic [7:0] DIM_CODE_SIX   = 8'd6;
  localparam logic [7:0] LIGHT_CODE_MAX = 8'd5;

  localparam logic [TIMEOUT_W-1:0] APO_SHORT_TICKS = TIMEOUT_W'(10 * TICKS_PER_MINUTE);
  localparam logic [TIMEOUT_W-1:0] APO_LONG_TICKS  = TIMEOUT_W'(60 * TICKS_PER_MINUTE);
  localparam logic [TIMEOUT_W-1:0] DIM_ONE_TICKS   = TIMEOUT_W'(1 * TICKS_PER_HALF_MINUTE);
  localparam logic [TIMEOUT_W-1:0] DIM_TWO_TICKS   = TIMEOUT_W'(2 * TICKS_PER_HALF_MINUTE);
  localparam logic [TIMEOUT_W-1:0] DIM_SIX_TICKS   = TIMEOUT_W'(6 * TICKS_PER_HALF_MINUTE);

  localparam logic [LIGHT_W-1:0] DIM_LEVEL = 3'd1;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_POLL    = 2'd1,
    OP_REFRESH = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_DOWN = 2'd1,
    KEY_UP   = 2'd2,
    KEY_HOLD = 2'd3
  } key_kind_t;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_AUTO_OFF  = 2'd1,
    CFG_DIM_DELAY = 2'd2,
    CFG_LIGHT     = 2'd3
  } cfg_index_t;

  // Decoded settings; a zero timeout means the feature is off.
  typedef struct packed {
    logic                 enable;
    logic [TIMEOUT_W-1:0] apo_ticks;
    logic [TIMEOUT_W-1:0] dim_ticks;
    logic [LIGHT_W-1:0]   user_light;
  } cfg_t;

  typedef struct packed {
    op_t               operation;
    logic [TICK_W-1:0] now_ticks;
    key_kind_t         key_kind;
    logic              key_is_ac_on;
    logic              shift_held;
    logic              alpha_held;
    logic              keyboard_idle;
    logic              may_sleep;
  } item_t;

  typedef struct packed {
    logic               dim_pwm_write;
    logic [LIGHT_W-1:0] light_level;
    logic               light_write;
    logic               power_off_now;
    logic               handled;
  } result_t;

endpackage

`default_nettype wire

[src/idpo_cfg.sv]
// ----------------------------------------------------------------------------
// idpo_cfg: settings registers
// Decodes the raw setting codes into the enable bit, timeouts and a light level on write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idpo_cfg
  import idpo_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  cfg_t cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE: begin
          cfg_reg.enable <= cfg_data[0];
        end
        CFG_AUTO_OFF: begin
          if (cfg_data == APO_CODE_SHORT) begin
            cfg_reg.apo_ticks <= APO_SHORT_TICKS;
          end else if (cfg_data == APO_CODE_LONG) begin
            cfg_reg.apo_ticks <= APO_LONG_TICKS;
          end else begin
            cfg_reg.apo_ticks <= '0;
          end
        end
        CFG_DIM_DELAY: begin
          if (cfg_data == DIM_CODE_ONE) begin
            cfg_reg.dim_ticks <= DIM_ONE_TICKS;
          end else if (cfg_data == DIM_CODE_TWO) begin
            cfg_reg.dim_ticks <= DIM_TWO_TICKS;
          end else if (cfg_data == DIM_CODE_SIX) begin
            cfg_reg.dim_ticks <= DIM_SIX_TICKS;
          end else begin
            cfg_reg.dim_ticks <= '0;
          end
        end
        CFG_LIGHT: begin
          if (cfg_data != 8'd0 && cfg_data <= LIGHT_CODE_MAX) begin
            cfg_reg.user_light <= cfg_data[LIGHT_W-1:0];
          end else begin
            cfg_reg.user_light <= '0;
          end
        end
        default: begin
          cfg_reg <= cfg_reg;
        end
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/idpo_core.sv]
// ----------------------------------------------------------------------------
// idpo_core: activity state and step logic
// Holds the activity state and computes one result per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idpo_core
  import idpo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  step,
  input  wire item_t item,
  output result_t    result
);

  logic [TICK_W-1:0] last_activity_ticks, last_activity_ticks_next;
  logic              activity_unseen, activity_unseen_next;
  logic              is_dimmed, is_dimmed_next;
  logic              manual_request, manual_request_next;
  logic              off_pending, off_pending_next;

  logic [ELAPSED_W-1:0] now_ext;
  logic [ELAPSED_W-1:0] last_ext;
  logic [ELAPSED_W-1:0] elapsed_raw;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 activity;
  logic                 dimmed_a;
  logic                 pending_a;
  logic                 pending_b;
  logic                 apo_hit;
  logic                 dim_hit;
  logic                 light_on;

  assign now_ext  = {1'b0, item.now_ticks};
  assign last_ext = {1'b0, last_activity_ticks};
  assign light_on = (cfg.user_light != '0);

  always_comb begin
    if (now_ext >= last_ext) begin
      elapsed_raw = now_ext - last_ext;
    end else begin
      elapsed_raw = now_ext + TICKS_PER_DAY - last_ext;
    end
  end

  // Activity on a poll moves the last-activity stamp to now, so the
  // elapsed time seen by the timeout checks is zero.
  assign activity  = activity_unseen || !item.keyboard_idle;
  assign elapsed   = activity ? '0 : elapsed_raw;
  assign dimmed_a  = activity ? 1'b0 : is_dimmed;
  assign pending_a = (activity && !manual_request) ? 1'b0 : off_pending;
  assign apo_hit   = (cfg.apo_ticks != '0) &&
                     (elapsed >= {{(ELAPSED_W-TIMEOUT_W){1'b0}}, cfg.apo_ticks});
  assign dim_hit   = (cfg.dim_ticks != '0) &&
                     (elapsed >= {{(ELAPSED_W-TIMEOUT_W){1'b0}}, cfg.dim_ticks});
  assign pending_b = pending_a || apo_hit;

  always_comb begin
    result                   = '0;
    last_activity_ticks_next = last_activity_ticks;
    activity_unseen_next     = activity_unseen;
    is_dimmed_next           = is_dimmed;
    manual_request_next      = manual_request;
    off_pending_next         = off_pending;

    if (cfg.enable) begin
      case (item.operation)
        OP_KEY: begin
          if (item.key_kind != KEY_NONE) begin
            activity_unseen_next = 1'b1;
          end
          if (item.key_kind == KEY_DOWN && item.key_is_ac_on &&
              item.shift_held && !item.alpha_held) begin
            manual_request_next = 1'b1;
            off_pending_next    = 1'b1;
            result.handled      = 1'b1;
          end
        end
        OP_POLL: begin
          if (activity) begin
            activity_unseen_next     = 1'b0;
            last_activity_ticks_next = item.now_ticks;
            if (is_dimmed && light_on) begin
              result.light_write = 1'b1;
              result.light_level = cfg.user_light;
            end
          end
          is_dimmed_next   = dimmed_a;
          off_pending_next = pending_b;
          if (pending_b) begin
            result.handled = 1'b1;
            if (item.may_sleep) begin
              if (dimmed_a && light_on) begin
                result.light_write = 1'b1;
                result.light_level = cfg.user_light;
              end
              result.power_off_now     = 1'b1;
              last_activity_ticks_next = item.now_ticks;
              activity_unseen_next     = 1'b0;
              is_dimmed_next           = 1'b0;
              manual_request_next      = 1'b0;
              off_pending_next         = 1'b0;
            end
          end else if (!dimmed_a && dim_hit && light_on) begin
            result.light_write   = 1'b1;
            result.light_level   = DIM_LEVEL;
            result.dim_pwm_write = 1'b1;
            is_dimmed_next       = 1'b1;
          end
        end
        OP_REFRESH: begin
          last_activity_ticks_next = item.now_ticks;
          activity_unseen_next     = 1'b0;
          is_dimmed_next           = 1'b0;
          manual_request_next      = 1'b0;
          off_pending_next         = 1'b0;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity_ticks <= '0;
      activity_unseen     <= 1'b0;
      is_dimmed           <= 1'b0;
      manual_request      <= 1'b0;
      off_pending         <= 1'b0;
    end else if (step) begin
      last_activity_ticks <= last_activity_ticks_next;
      activity_unseen     <= activity_unseen_next;
      is_dimmed           <= is_dimmed_next;
      manual_request      <= manual_request_next;
      off_pending         <= off_pending_next;
    end
  end

`ifndef SYNTHESIS
  // A manual request is always backed by a pending power-off.
  a_manual_pending: assert property (@(posedge clk) disable iff (rst)
    manual_request |-> off_pending)
    else $error("manual request without pending power-off");
`endif

endmodule

`default_nettype wire

[src/inactivity_dim_and_auto_power_off.sv]
// Path: an accepted word passes the input register, then the output register.
// Throughput: one word per cycle while the output is not stalled; the step logic is a
//   single pass between the input register and the output register, with the activity
//   state updated as each word moves into the output register.
// Reset: synchronous, active high; clears settings, activity state and both
//   pipeline valid flags.
// ----------------------------------------------------------------------------
// inactivity_dim_and_auto_power_off: backlight dimmer and auto power-off
// Takes key events, polls and refresh commands stamped with a daily tick
// count and returns one action word per input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module inactivity_dim_and_auto_power_off
  import idpo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Settings write port.
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, low bit up: now_ticks[23:0], key_kind[25:24], key_is_ac_on[26],
  // shift_held[27], alpha_held[28], keyboard_idle[29], may_sleep[30], zero[31].
  input  wire logic [31:0] s_tdata,
  // s_tuser: operation[1:0].
  input  wire logic [1:0]  s_tuser,
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, low bit up: handled[0], power_off_now[1], light_write[2],
  // light_level[5:3], dim_pwm_write[6], zero[7].
  output logic [7:0]       m_tdata
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t result;

  idpo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the incoming word.
  assign in_item.operation     = op_t'(s_tuser);
  assign in_item.now_ticks     = s_tdata[23:0];
  assign in_item.key_kind      = key_kind_t'(s_tdata[25:24]);
  assign in_item.key_is_ac_on  = s_tdata[26];
  assign in_item.shift_held    = s_tdata[27];
  assign in_item.alpha_held    = s_tdata[28];
  assign in_item.keyboard_idle = s_tdata[29];
  assign in_item.may_sleep     = s_tdata[30];

  // The held word moves on whenever the output register is empty or is
  // being drained in this cycle; the input register refills in the same
  // cycle, so back-to-back words flow with no bubble.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= in_item;
    end
  end

  // The core updates its activity state only on the cycle the word is
  // committed to the output register.
  idpo_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, result};
    end
  end

`ifndef SYNTHESIS
  a_off_handled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("power-off word without handled flag");

  a_level_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[5:3] == 3'd0))
    else $error("light level set without light write");

  a_dim_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6]) |-> (m_tdata[2] && m_tdata[5:3] == DIM_LEVEL && !m_tdata[0]))
    else $error("dim word with wrong light fields");

  a_drain_accept: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && s1_valid) |-> s_tready)
    else $error("input stalled while output register empty");
`endif

endmodule

`default_nettype wire
